// ===== src/avw_pkg.sv =====
// Shared types, constants and serial arithmetic steps for the ADSR wavetable voice.
// Used by avw_muldiv and adsr_wavetable_voice_top; no dependencies.
package avw_pkg;

    localparam int unsigned CFG_W         = 16;
    localparam int unsigned OPW           = 16;
    localparam int unsigned MCAND_W       = 17;
    localparam int unsigned ACC_W         = MCAND_W + OPW;
    localparam int unsigned DIGIT         = 2;
    localparam int unsigned MD_STEPS      = OPW / DIGIT;
    localparam int unsigned MD_CW         = $clog2(MD_STEPS);
    localparam int unsigned DAC_W         = 12;
    localparam int unsigned NUM_W         = 30;
    localparam int unsigned TABLE_DEPTH_DEF = 1024;

    localparam logic [CFG_W-1:0] ATTACK_LEN_RST  = 16'd220;
    localparam logic [CFG_W-1:0] DECAY_LEN_RST   = 16'd22050;
    localparam logic [CFG_W-1:0] RELEASE_LEN_RST = 16'd6615;
    localparam logic [CFG_W-1:0] PEAK_AMP_RST    = 16'd32768;
    localparam logic [CFG_W-1:0] SUSTAIN_AMP_RST = 16'd2621;

    localparam logic [DAC_W-1:0] DAC_MID    = 12'd2047;
    // 4095 * 65536: mid-scale offset of the doubled-sample product
    localparam logic [NUM_W-1:0] DAC_BIAS   = 30'h0FFF_0000;
    localparam logic [13:0]      SAMPLE_OFS = 14'd4095;

    // register indexes on the config port
    localparam logic [2:0] CFG_ATTACK_LEN  = 3'd0;
    localparam logic [2:0] CFG_DECAY_LEN   = 3'd1;
    localparam logic [2:0] CFG_RELEASE_LEN = 3'd2;
    localparam logic [2:0] CFG_PEAK_AMP    = 3'd3;
    localparam logic [2:0] CFG_SUSTAIN_AMP = 3'd4;

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_NOTE_ON  = 2'd1,
        KIND_NOTE_OFF = 2'd2,
        KIND_TABLE_WR = 2'd3
    } avw_kind_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } avw_phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_RUN,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_ENV,
        ST_DAC_RUN,
        ST_OUT
    } avw_state_t;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } avw_op_t;

    typedef struct packed {
        logic               start;
        avw_op_t            op;
        logic [MCAND_W-1:0] mcand;     // two's complement multiplicand
        logic [OPW-1:0]     mplier;
        logic [OPW-1:0]     divisor;
    } avw_md_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } avw_md_stat_t;

    // One shift-add step: acc = {high (signed), multiplier bits still to go}.
    function automatic logic [ACC_W-1:0] mul_step(logic [ACC_W-1:0] acc,
                                                  logic [MCAND_W-1:0] mcand);
        logic signed [MCAND_W:0] sum;
        sum = $signed({acc[ACC_W-1], acc[ACC_W-1:OPW]})
            + (acc[0] ? $signed({mcand[MCAND_W-1], mcand}) : $signed({(MCAND_W+1){1'b0}}));
        return {sum, acc[OPW-1:1]};
    endfunction

    // One restoring step: acc = {0, remainder, dividend bits / quotient bits}.
    function automatic logic [ACC_W-1:0] div_step(logic [ACC_W-1:0] acc,
                                                  logic [OPW-1:0] divisor);
        logic [OPW:0] trial;
        logic [OPW:0] rem;
        logic         ge;
        trial = {acc[2*OPW-1:OPW], acc[OPW-1]};
        ge    = (trial >= {1'b0, divisor});
        rem   = ge ? (trial - {1'b0, divisor}) : trial;
        return {1'b0, rem[OPW-1:0], acc[OPW-2:0], ge};
    endfunction

endpackage

// ===== src/avw_muldiv.sv =====
// Shared serial multiply / divide unit, two bits per cycle.
// Depends on avw_pkg (step functions, control and status structs).
module avw_muldiv (
    input  logic                      clk,
    input  logic                      rst_n,
    input  avw_pkg::avw_md_ctl_t      ctl,
    output avw_pkg::avw_md_stat_t     stat,
    output logic [avw_pkg::ACC_W-1:0] result
);

    localparam logic [avw_pkg::MD_CW-1:0] CNT_LAST = avw_pkg::MD_CW'(avw_pkg::MD_STEPS - 1);

    logic                          busy_reg;
    logic [avw_pkg::MD_CW-1:0]     cnt_reg;
    avw_pkg::avw_op_t              op_reg;
    logic [avw_pkg::ACC_W-1:0]     acc_reg;
    logic [avw_pkg::ACC_W-1:0]     acc_next;
    logic [avw_pkg::MCAND_W-1:0]   mcand_reg;
    logic [avw_pkg::OPW-1:0]       divisor_reg;

    always_comb
    begin
        acc_next = acc_reg;
        for (int i = 0; i < avw_pkg::DIGIT; i++)
        begin
            if (op_reg == avw_pkg::OP_MUL)
            begin
                acc_next = avw_pkg::mul_step(acc_next, mcand_reg);
            end
            else
            begin
                acc_next = avw_pkg::div_step(acc_next, divisor_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= avw_pkg::OP_MUL;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            op_reg   <= ctl.op;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // divide continues from the product left in acc_reg
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            mcand_reg   <= ctl.mcand;
            divisor_reg <= ctl.divisor;
            if (ctl.op == avw_pkg::OP_MUL)
            begin
                acc_reg <= {{(avw_pkg::ACC_W - avw_pkg::OPW){1'b0}}, ctl.mplier};
            end
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (cnt_reg == CNT_LAST);
    assign result    = acc_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |-> !busy_reg)
        else $error("muldiv started while busy");

    a_done_timing: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |-> ##(avw_pkg::MD_STEPS) stat.done)
        else $error("muldiv done not on schedule");

    // quotient fits 16 bits only while the partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && op_reg == avw_pkg::OP_DIV)
        |-> (!acc_reg[avw_pkg::ACC_W-1]
             && (acc_reg[2*avw_pkg::OPW-1:avw_pkg::OPW] < divisor_reg)))
        else $error("division remainder out of range");

endmodule

// ===== src/adsr_wavetable_voice_top.sv =====
// Top level of the ADSR wavetable voice: control FSM, envelope state, wave table.
// Depends on avw_pkg and avw_muldiv.
// Table write, note on, note off: accepted while idle, no result.
// Tick: in attack, decay and release the result takes three passes through the shared
// 2-bit-per-cycle multiply/divide unit (multiply, divide, DAC multiply), two on the release tick
// that ends the note (no DAC multiply), one in sustain (DAC multiply only), none idle.
// Next item is taken once the result is loaded into the output register.
// Reset (async, active low): config registers to defaults, envelope idle; table undefined.
module adsr_wavetable_voice_top #(
    parameter int unsigned TABLE_DEPTH = avw_pkg::TABLE_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_index,
    input  logic [avw_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                kind,
    input  logic [9:0]                table_index,
    input  logic [11:0]               table_value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [avw_pkg::DAC_W-1:0] dac_value,
    output logic                      voice_active
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] POS_LAST = AW'(TABLE_DEPTH - 1);
    localparam logic [16:0]   DEPTH_EXT = 17'(TABLE_DEPTH);

    avw_pkg::avw_state_t state_reg, state_next;

    logic [15:0] attack_len_reg, decay_len_reg, release_len_reg;
    logic [15:0] peak_amp_reg, sustain_amp_reg;

    avw_pkg::avw_phase_t phase_reg, phase_step;
    logic [15:0]         count_reg, count_step;
    logic [15:0]         env_reg, env_step;
    logic [15:0]         rel_from_reg;
    logic [AW-1:0]       wave_pos_reg;

    logic [11:0] tbl_mem [TABLE_DEPTH];
    logic [11:0] tbl_rdata_reg;
    logic [16:0] tbl_idx_ext;
    logic        tbl_we;

    logic                      out_valid_reg;
    logic [avw_pkg::DAC_W-1:0] dac_reg;
    logic                      active_reg;
    logic                      out_load;

    logic in_fire, tick_fire, timed_phase;

    logic [15:0] len_sel, len_eff, cnt_sat, diff_abs, quot;
    logic [16:0] count_inc;
    logic        phase_end, sus_le_peak;
    logic [15:0] timed_mcand, timed_mplier;
    logic [13:0] samp_ofs;
    logic [avw_pkg::MCAND_W-1:0] dac_mcand;
    logic [avw_pkg::NUM_W-1:0]   dac_num;

    avw_pkg::avw_md_ctl_t      md_ctl;
    avw_pkg::avw_md_stat_t     md_stat;
    logic [avw_pkg::ACC_W-1:0] md_result;

    avw_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (md_ctl),
        .stat   (md_stat),
        .result (md_result)
    );

    assign in_fire     = in_valid && in_ready;
    assign tick_fire   = in_fire && (kind == avw_pkg::KIND_TICK);
    assign timed_phase = (phase_reg == avw_pkg::PH_ATTACK) || (phase_reg == avw_pkg::PH_DECAY)
                      || (phase_reg == avw_pkg::PH_RELEASE);

    // ---------------- operand selection ----------------
    always_comb
    begin
        unique case (phase_reg)
            avw_pkg::PH_DECAY:   len_sel = decay_len_reg;
            avw_pkg::PH_RELEASE: len_sel = release_len_reg;
            default:             len_sel = attack_len_reg;
        endcase
    end

    assign len_eff     = (len_sel == 16'd0) ? 16'd1 : len_sel;
    assign cnt_sat     = (count_reg > len_eff) ? len_eff : count_reg;
    assign count_inc   = {1'b0, count_reg} + 17'd1;
    assign phase_end   = (count_inc >= {1'b0, len_eff});
    assign sus_le_peak = (sustain_amp_reg <= peak_amp_reg);
    assign diff_abs    = sus_le_peak ? (peak_amp_reg - sustain_amp_reg)
                                     : (sustain_amp_reg - peak_amp_reg);
    assign quot        = md_result[15:0];

    always_comb
    begin
        unique case (phase_reg)
            avw_pkg::PH_DECAY:
            begin
                timed_mcand  = diff_abs;
                timed_mplier = cnt_sat;
            end
            avw_pkg::PH_RELEASE:
            begin
                timed_mcand  = rel_from_reg;
                timed_mplier = len_eff - cnt_sat;
            end
            default:
            begin
                timed_mcand  = peak_amp_reg;
                timed_mplier = cnt_sat;
            end
        endcase
    end

    // sample - 2047.5, doubled
    assign samp_ofs  = {1'b0, tbl_rdata_reg, 1'b0} - avw_pkg::SAMPLE_OFS;
    assign dac_mcand = {{(avw_pkg::MCAND_W - 14){samp_ofs[13]}}, samp_ofs};
    // stays within 0 .. 2^29 - 1 for every sample and envelope
    assign dac_num   = avw_pkg::DAC_BIAS + md_result[avw_pkg::NUM_W-1:0];

    // ---------------- envelope step ----------------
    always_comb
    begin
        phase_step = phase_reg;
        count_step = count_reg;
        env_step   = env_reg;
        unique case (phase_reg)
            avw_pkg::PH_ATTACK:
            begin
                env_step   = quot;
                count_step = phase_end ? 16'd0 : count_inc[15:0];
                phase_step = phase_end ? avw_pkg::PH_DECAY : avw_pkg::PH_ATTACK;
            end
            avw_pkg::PH_DECAY:
            begin
                env_step   = sus_le_peak ? (peak_amp_reg - quot) : (peak_amp_reg + quot);
                count_step = phase_end ? 16'd0 : count_inc[15:0];
                phase_step = phase_end ? avw_pkg::PH_SUSTAIN : avw_pkg::PH_DECAY;
            end
            avw_pkg::PH_SUSTAIN:
            begin
                env_step = sustain_amp_reg;
            end
            avw_pkg::PH_RELEASE:
            begin
                count_step = count_inc[15:0];
                if (phase_end || (quot == 16'd0))
                begin
                    env_step   = 16'd0;
                    phase_step = avw_pkg::PH_IDLE;
                end
                else
                begin
                    env_step = quot;
                end
            end
            default:
            begin
                env_step   = 16'd0;
                phase_step = avw_pkg::PH_IDLE;
            end
        endcase
    end

    // ---------------- FSM: next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            avw_pkg::ST_IDLE:
            begin
                if (tick_fire)
                begin
                    state_next = timed_phase ? avw_pkg::ST_MUL_RUN : avw_pkg::ST_ENV;
                end
            end
            avw_pkg::ST_MUL_RUN:
            begin
                if (md_stat.done)
                begin
                    state_next = avw_pkg::ST_DIV_START;
                end
            end
            avw_pkg::ST_DIV_START:
            begin
                state_next = avw_pkg::ST_DIV_RUN;
            end
            avw_pkg::ST_DIV_RUN:
            begin
                if (md_stat.done)
                begin
                    state_next = avw_pkg::ST_ENV;
                end
            end
            avw_pkg::ST_ENV:
            begin
                state_next = (phase_step == avw_pkg::PH_IDLE) ? avw_pkg::ST_OUT
                                                              : avw_pkg::ST_DAC_RUN;
            end
            avw_pkg::ST_DAC_RUN:
            begin
                if (md_stat.done)
                begin
                    state_next = avw_pkg::ST_OUT;
                end
            end
            avw_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = avw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = avw_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- FSM: outputs ----------------
    always_comb
    begin
        in_ready       = 1'b0;
        out_load       = 1'b0;
        md_ctl.start   = 1'b0;
        md_ctl.op      = avw_pkg::OP_MUL;
        md_ctl.mcand   = {1'b0, timed_mcand};
        md_ctl.mplier  = timed_mplier;
        md_ctl.divisor = len_eff;
        unique case (state_reg)
            avw_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                md_ctl.start = tick_fire && timed_phase;
            end
            avw_pkg::ST_DIV_START:
            begin
                md_ctl.start = 1'b1;
                md_ctl.op    = avw_pkg::OP_DIV;
            end
            avw_pkg::ST_ENV:
            begin
                md_ctl.start  = (phase_step != avw_pkg::PH_IDLE);
                md_ctl.mcand  = dac_mcand;
                md_ctl.mplier = env_step;
            end
            avw_pkg::ST_OUT:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // ---------------- control and envelope registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= avw_pkg::ST_IDLE;
            attack_len_reg  <= avw_pkg::ATTACK_LEN_RST;
            decay_len_reg   <= avw_pkg::DECAY_LEN_RST;
            release_len_reg <= avw_pkg::RELEASE_LEN_RST;
            peak_amp_reg    <= avw_pkg::PEAK_AMP_RST;
            sustain_amp_reg <= avw_pkg::SUSTAIN_AMP_RST;
            phase_reg       <= avw_pkg::PH_IDLE;
            count_reg       <= 16'd0;
            env_reg         <= 16'd0;
            rel_from_reg    <= 16'd0;
            wave_pos_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    avw_pkg::CFG_ATTACK_LEN:  attack_len_reg  <= cfg_wdata;
                    avw_pkg::CFG_DECAY_LEN:   decay_len_reg   <= cfg_wdata;
                    avw_pkg::CFG_RELEASE_LEN: release_len_reg <= cfg_wdata;
                    avw_pkg::CFG_PEAK_AMP:    peak_amp_reg    <= cfg_wdata;
                    avw_pkg::CFG_SUSTAIN_AMP: sustain_amp_reg <= cfg_wdata;
                    default:                  ;
                endcase
            end

            if (in_fire && (kind == avw_pkg::KIND_NOTE_ON))
            begin
                wave_pos_reg <= '0;
                count_reg    <= 16'd0;
                phase_reg    <= avw_pkg::PH_ATTACK;
            end
            else if (in_fire && (kind == avw_pkg::KIND_NOTE_OFF))
            begin
                if ((phase_reg != avw_pkg::PH_IDLE) && (phase_reg != avw_pkg::PH_RELEASE))
                begin
                    rel_from_reg <= env_reg;
                    count_reg    <= 16'd0;
                    phase_reg    <= avw_pkg::PH_RELEASE;
                end
            end
            else if (state_reg == avw_pkg::ST_ENV)
            begin
                env_reg   <= env_step;
                count_reg <= count_step;
                phase_reg <= phase_step;
            end
            else if (out_load && (phase_reg != avw_pkg::PH_IDLE))
            begin
                wave_pos_reg <= (wave_pos_reg == POS_LAST) ? '0 : wave_pos_reg + 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (phase_reg == avw_pkg::PH_IDLE)
            begin
                dac_reg    <= avw_pkg::DAC_MID;
                active_reg <= 1'b0;
            end
            else
            begin
                dac_reg    <= dac_num[28:17];
                active_reg <= 1'b1;
            end
        end
    end

    // ---------------- wave table ----------------
    assign tbl_idx_ext = {7'd0, table_index};
    assign tbl_we      = in_fire && (kind == avw_pkg::KIND_TABLE_WR) && (tbl_idx_ext < DEPTH_EXT);

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_idx_ext[AW-1:0]] <= table_value;
        end
        tbl_rdata_reg <= tbl_mem[wave_pos_reg];
    end

    assign out_valid    = out_valid_reg;
    assign dac_value    = dac_reg;
    assign voice_active = active_reg;

    a_idle_env_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == avw_pkg::PH_IDLE) |-> (env_reg == 16'd0))
        else $error("envelope nonzero while idle");

    a_dac_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == avw_pkg::ST_OUT) && (phase_reg != avw_pkg::PH_IDLE)) |-> !dac_num[29])
        else $error("DAC numerator out of range");

    a_idle_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !voice_active) |-> (dac_value == avw_pkg::DAC_MID))
        else $error("inactive voice result not mid-scale");

endmodule
